/* rtl/cctif_pkg.sv */
// ----------------------------------------------------------------------------
// cctif_pkg
// Shared types and constants for the compact code to IEEE float expander.
// ----------------------------------------------------------------------------
`default_nettype none

package cctif_pkg;

    // Configuration register indexes and port widths
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEN = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DBL = 4'd1;

    // Supported code lengths and reset length
    localparam logic [4:0] LEN_12    = 5'd12;
    localparam logic [4:0] LEN_13    = 5'd13;
    localparam logic [4:0] LEN_16    = 5'd16;
    localparam logic [4:0] LEN_20    = 5'd20;
    localparam logic [4:0] LEN_RESET = LEN_16;

    // Precision bit counts per supported length
    localparam logic [3:0] PB_12 = 4'd6;
    localparam logic [3:0] PB_13 = 4'd7;
    localparam logic [3:0] PB_16 = 4'd10;
    localparam logic [3:0] PB_20 = 4'd14;

    // Magnitude that drops the implicit leading one
    localparam logic [3:0] MAG_NO_LEAD = 4'hF;

    // IEEE format constants
    localparam logic [4:0]  EW_SP   = 5'd8;
    localparam logic [4:0]  EW_DP   = 5'd11;
    localparam logic [5:0]  MW_SP   = 6'd23;
    localparam logic [5:0]  MW_DP   = 6'd52;
    localparam logic [10:0] BIAS_SP = 11'd127;
    localparam logic [10:0] BIAS_DP = 11'd1023;
    localparam logic [10:0] EMAX_SP = 11'd254;
    localparam logic [10:0] EMAX_DP = 11'd2046;

    // Live configuration
    typedef struct packed {
        logic [4:0] len;
        logic       dbl;
    } t_cfg;

    // Decoded code, after the first stage
    typedef struct packed {
        logic        sgn;
        logic        esgn;
        logic [14:0] stream;
        logic [4:0]  slen;
        logic        dbl;
        logic        err;
    } t_dec;

    // Exponent offset and mantissa, after the second stage
    typedef struct packed {
        logic        sgn;
        logic        esgn;
        logic [15:0] efield;
        logic [51:0] mant;
        logic        dbl;
        logic        err;
    } t_spl;

    // Final result
    typedef struct packed {
        logic [63:0] bits;
        logic        err;
    } t_res;

endpackage

`default_nettype wire

/* rtl/cctif_decode.sv */
// ----------------------------------------------------------------------------
// cctif_decode
// First stage: split the code into sign, exponent sign and bit stream.
// ----------------------------------------------------------------------------
`default_nettype none

module cctif_decode
    import cctif_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [19:0] i_code,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_dec             o_dec
);

    logic        r_vld;
    t_dec        r_dec;
    t_dec        n_dec;
    logic [3:0]  w_pb;
    logic        w_err;
    logic [19:0] w_hi;
    logic [3:0]  w_mag;
    logic [13:0] w_prec;
    logic        w_lead;

    // Pick the precision width for the configured length
    always_comb begin
        w_pb  = PB_16;
        w_err = 1'b0;
        case (i_cfg.len)
            LEN_12:  w_pb = PB_12;
            LEN_13:  w_pb = PB_13;
            LEN_16:  w_pb = PB_16;
            LEN_20:  w_pb = PB_20;
            default: w_err = 1'b1;
        endcase
    end

    // Form the fields and the bit stream
    always_comb begin
        w_hi   = i_code >> w_pb;
        w_mag  = w_hi[3:0];
        w_prec = i_code[13:0] & ~(14'h3FFF << w_pb);
        w_lead = (w_mag != MAG_NO_LEAD);

        n_dec.sgn    = w_hi[5];
        n_dec.esgn   = w_hi[4];
        n_dec.stream = {1'b0, w_prec} | (w_lead ? (15'd1 << w_pb) : 15'd0);
        n_dec.slen   = 5'd1 + {1'b0, w_mag} + {4'b0, w_lead} + {1'b0, w_pb};
        n_dec.dbl    = i_cfg.dbl;
        n_dec.err    = w_err;
    end

    // Advance when the register is empty or drains downstream
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_dec <= n_dec;
        end
    end

    assign o_valid = r_vld;
    assign o_dec   = r_dec;

endmodule

`default_nettype wire

/* rtl/cctif_split.sv */
// ----------------------------------------------------------------------------
// cctif_split
// Second stage: cut the bit stream into exponent offset and mantissa.
// ----------------------------------------------------------------------------
`default_nettype none

module cctif_split
    import cctif_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_dec i_dec,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_spl      o_spl
);

    logic        r_vld;
    t_spl        r_spl;
    t_spl        n_spl;
    logic [4:0]  w_ew;
    logic [5:0]  w_mw;
    logic        w_ge;
    logic [4:0]  w_rest;
    logic [4:0]  w_shl;
    logic [14:0] w_masked;
    logic [17:0] w_eshl;
    logic [14:0] w_eshr;
    logic [5:0]  w_mshl;
    logic [51:0] w_mant;

    // Split the stream at the exponent width
    always_comb begin
        w_ew     = i_dec.dbl ? EW_DP : EW_SP;
        w_mw     = i_dec.dbl ? MW_DP : MW_SP;
        w_ge     = (i_dec.slen >= w_ew);
        w_rest   = i_dec.slen - w_ew;
        w_shl    = w_ew - i_dec.slen;
        w_eshr   = i_dec.stream >> w_rest;
        w_eshl   = {3'b0, i_dec.stream} << w_shl;
        w_masked = i_dec.stream & ~(15'h7FFF << w_rest);
        w_mshl   = w_mw - {1'b0, w_rest};
        w_mant   = {37'b0, w_masked} << w_mshl;

        n_spl.sgn    = i_dec.sgn;
        n_spl.esgn   = i_dec.esgn;
        n_spl.efield = w_ge ? {1'b0, w_eshr} : w_eshl[15:0];
        n_spl.mant   = w_ge ? w_mant : 52'd0;
        n_spl.dbl    = i_dec.dbl;
        n_spl.err    = i_dec.err;
    end

    // Advance when the register is empty or drains downstream
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_spl <= n_spl;
        end
    end

    assign o_valid = r_vld;
    assign o_spl   = r_spl;

endmodule

`default_nettype wire

/* rtl/cctif_pack.sv */
// ----------------------------------------------------------------------------
// cctif_pack
// Third stage: bias and clamp the exponent, assemble the IEEE pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module cctif_pack
    import cctif_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_spl i_spl,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_res      o_res
);

    logic               r_vld;
    logic               r_dbl;
    t_res               r_res;
    t_res               n_res;
    logic [10:0]        w_bias;
    logic [10:0]        w_emax;
    logic [16:0]        w_off;
    logic signed [18:0] w_bexp;
    logic [10:0]        w_exp;

    // Apply the offset to the bias and saturate below the Inf code
    always_comb begin
        w_bias = i_spl.dbl ? BIAS_DP : BIAS_SP;
        w_emax = i_spl.dbl ? EMAX_DP : EMAX_SP;
        w_off  = {1'b0, i_spl.efield} + {16'b0, i_spl.esgn};
        if (i_spl.esgn) begin
            w_bexp = $signed({8'b0, w_bias}) - $signed({2'b0, w_off});
        end else begin
            w_bexp = $signed({8'b0, w_bias}) + $signed({2'b0, w_off});
        end
        if (w_bexp < 0) begin
            w_exp = 11'd0;
        end else if (w_bexp > $signed({8'b0, w_emax})) begin
            w_exp = w_emax;
        end else begin
            w_exp = w_bexp[10:0];
        end
    end

    // Assemble the pattern; an unsupported length gives zero
    always_comb begin
        n_res.err = i_spl.err;
        if (i_spl.err) begin
            n_res.bits = 64'd0;
        end else if (i_spl.dbl) begin
            n_res.bits = {i_spl.sgn, w_exp, i_spl.mant};
        end else begin
            n_res.bits = {32'd0, i_spl.sgn, w_exp[7:0], i_spl.mant[22:0]};
        end
    end

    // Hold the result until the receiver takes the beat
    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_res <= n_res;
            r_dbl <= i_spl.dbl;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_res.err |-> r_res.bits == 64'd0)
        else $error("length error beat carries a non-zero pattern");

    a_single_upper: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_dbl |-> r_res.bits[63:32] == 32'd0)
        else $error("single precision beat has upper word set");

    a_no_inf_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_dbl |-> r_res.bits[30:23] != 8'hFF)
        else $error("single precision exponent reached the Inf code");

    a_no_inf_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && r_dbl |-> r_res.bits[62:52] != 11'h7FF)
        else $error("double precision exponent reached the Inf code");
`endif

endmodule

`default_nettype wire

/* rtl/compact_code_to_ieee_float.sv */
// ----------------------------------------------------------------------------
// compact_code_to_ieee_float
// Expands compact codes of 12, 13, 16 or 20 bits to IEEE bit patterns.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one code per beat in i_code,
//   right-aligned. Output channel o_valid/i_ready returns one result beat
//   per code: o_ieee_bits (single precision in the low word) and
//   o_length_error, set with a zero pattern when the code length is not
//   supported.
//   Configuration channel i_cfg_valid/o_cfg_ready writes register
//   i_cfg_index with i_cfg_data: index 0 code length, index 1 double
//   select. Writes are taken every cycle; write only while idle.
//   An accepted code passes the decode, split and pack register stages
//   on its way to o_valid. Throughput is one code per cycle while the
//   receiver keeps up. Each stage holds its beat when the next one is
//   full, so a stalled receiver backs the pipeline up one stage at a time
//   and an empty stage still takes a beat.
//   Reset empties the pipeline and sets code length 16, single precision.
// ----------------------------------------------------------------------------
`default_nettype none

module compact_code_to_ieee_float
    import cctif_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [19:0]           i_code,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [63:0]                o_ieee_bits,
    output logic                       o_length_error
);

    t_cfg r_cfg;
    logic w_dec_vld;
    logic w_dec_rdy;
    t_dec w_dec;
    logic w_spl_vld;
    logic w_spl_rdy;
    t_spl w_spl;
    t_res w_res;

    // Configuration registers; unknown indexes drop the write
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len <= LEN_RESET;
            r_cfg.dbl <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_LEN: r_cfg.len <= i_cfg_data[4:0];
                CFG_IDX_DBL: r_cfg.dbl <= i_cfg_data[0];
                default:     r_cfg     <= r_cfg;
            endcase
        end
    end

    cctif_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_code  (i_code),
        .o_valid (w_dec_vld),
        .i_ready (w_dec_rdy),
        .o_dec   (w_dec)
    );

    cctif_split u_split (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dec_vld),
        .o_ready (w_dec_rdy),
        .i_dec   (w_dec),
        .o_valid (w_spl_vld),
        .i_ready (w_spl_rdy),
        .o_spl   (w_spl)
    );

    cctif_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_spl_vld),
        .o_ready (w_spl_rdy),
        .i_spl   (w_spl),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (w_res)
    );

    assign o_ieee_bits    = w_res.bits;
    assign o_length_error = w_res.err;

endmodule

`default_nettype wire
